// ===== rtl/tkr_pkg.sv =====
package tkr_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_KEEP_COUNT   = 2'd0,
        REG_BUFFER_LIMIT = 2'd1
    } t_reg_idx;

    // request codes
    typedef enum logic {
        REQ_RECORD = 1'b0,
        REQ_DRAIN  = 1'b1
    } t_req;

    // fixed register field widths
    localparam int KEEP_REG_W  = 5;
    localparam int LIMIT_REG_W = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int REASON_W    = 2;

    // default parameter values
    localparam int DEF_MAX_BUFFER = 32;
    localparam int DEF_MAX_KEEP   = 16;
    localparam int DEF_KEY_WIDTH  = 32;
    localparam int DEF_TAG_WIDTH  = 16;

    // register reset values
    localparam logic [KEEP_REG_W-1:0]  KEEP_RST  = 5'd8;
    localparam logic [LIMIT_REG_W-1:0] LIMIT_RST = 6'd32;

    // operation broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD     = 3'd0,
        CELL_LOAD     = 3'd1,
        CELL_SORT_EVN = 3'd2,
        CELL_SORT_ODD = 3'd3,
        CELL_CUT      = 3'd4,
        CELL_SHIFT    = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

endpackage

// ===== rtl/tkr_cell.sv =====
module tkr_cell
    import tkr_pkg::*;
#(
    parameter int ENT_W     = 50,
    parameter int KEY_WIDTH = 32,
    parameter int CW        = 6,
    parameter int INDEX     = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [CW-1:0]    i_keep,
    input  logic [ENT_W-1:0] i_new,
    input  logic [ENT_W-1:0] i_left_data,
    input  logic             i_left_valid,
    input  logic [ENT_W-1:0] i_right_data,
    input  logic             i_right_valid,
    output logic [ENT_W-1:0] o_data,
    output logic             o_valid
);

    localparam logic PAR = 1'(INDEX % 2);

    logic [ENT_W-1:0] r_data, n_data;
    logic             r_valid, n_valid;
    logic             w_phase;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        w_phase = (i_ctl.op == CELL_SORT_ODD);
        case (i_ctl.op)
            CELL_LOAD: begin
                if (!r_valid && ((INDEX == 0) || i_left_valid)) begin
                    n_data  = i_new;
                    n_valid = 1'b1;
                end
            end
            CELL_SORT_EVN, CELL_SORT_ODD: begin
                // left member of a pair takes the smaller, right the larger; strict compare keeps ties
                if (w_phase == PAR) begin
                    if (r_valid && i_right_valid &&
                        (r_data[KEY_WIDTH-1:0] > i_right_data[KEY_WIDTH-1:0])) begin
                        n_data = i_right_data;
                    end
                end else begin
                    if (r_valid && i_left_valid &&
                        (i_left_data[KEY_WIDTH-1:0] > r_data[KEY_WIDTH-1:0])) begin
                        n_data = i_left_data;
                    end
                end
            end
            CELL_CUT: begin
                if (CW'(INDEX) >= i_keep) begin
                    n_valid = 1'b0;
                end
            end
            CELL_SHIFT: begin
                n_data  = i_right_data;
                n_valid = i_right_valid;
            end
            default: begin
                n_data  = r_data;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

// ===== rtl/top_k_min_key_recorder.sv =====
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+---------------------------------------
// in        | input     | i_in_valid / o_in_stall    | req_type, case_tag, reason_code, key
// out       | output    | o_out_valid / i_out_stall  | tag, reason, key, empty, last
// cfg       | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a record beat that does not trigger compaction leaves the input unstalled, the next beat follows at once
// compaction is an odd-even transposition sort over the cell row: MAX_BUFFER+1 passes and then a
// cut; a drain then gives one beat per cycle from cell 0 while the output is not stalled
// reset is synchronous and clears all cell valid bits at once, no clearing pass
// stalls on the output freeze the cell row; the input stays stalled until a drain is finished
module top_k_min_key_recorder
    import tkr_pkg::*;
#(
    parameter int MAX_BUFFER = DEF_MAX_BUFFER,
    parameter int MAX_KEEP   = DEF_MAX_KEEP,
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
    parameter int TAG_WIDTH  = DEF_TAG_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_req_type,
    input  logic [TAG_WIDTH-1:0]   i_case_tag,
    input  logic [REASON_W-1:0]    i_reason_code,
    input  logic [KEY_WIDTH-1:0]   i_accuracy_key,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [TAG_WIDTH-1:0]   o_out_tag,
    output logic [REASON_W-1:0]    o_out_reason,
    output logic [KEY_WIDTH-1:0]   o_out_key,
    output logic                   o_out_empty,
    output logic                   o_out_last,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NCELL = MAX_BUFFER + 1;
    localparam int ENT_W = TAG_WIDTH + REASON_W + KEY_WIDTH;
    localparam int CNT_W = $clog2(MAX_BUFFER + 2);
    localparam int LW    = (CNT_W > LIMIT_REG_W) ? CNT_W : LIMIT_REG_W;
    localparam int KTOP  = (MAX_KEEP < MAX_BUFFER) ? MAX_KEEP : MAX_BUFFER;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_CUT,
        ST_DRAIN,
        ST_EMPTY
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_pass, n_pass;
    logic [KEY_WIDTH-1:0]    r_thr, n_thr;
    logic                    r_from_drain, n_from_drain;
    logic [KEEP_REG_W-1:0]   r_keep, n_keep;
    logic [LIMIT_REG_W-1:0]  r_limit, n_limit;

    logic [LW-1:0]           w_keff, w_lim, w_count_ext;
    logic                    w_in_acc, w_out_acc, w_drop;
    logic [KEY_WIDTH-1:0]    w_cut_key;
    t_cell_ctl               w_ctl;
    logic [ENT_W-1:0]        w_new;
    logic [ENT_W-1:0]        w_data  [NCELL];
    logic                    w_valid [NCELL];

    // effective keep count and limit, clamped
    always_comb begin
        w_keff = LW'(r_keep);
        if (w_keff < LW'(1))    w_keff = LW'(1);
        if (w_keff > LW'(KTOP)) w_keff = LW'(KTOP);
        w_lim = LW'(r_limit);
        if (w_lim < w_keff)           w_lim = w_keff;
        if (w_lim > LW'(MAX_BUFFER))  w_lim = LW'(MAX_BUFFER);
    end

    assign w_count_ext = LW'(r_count);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign w_drop      = (w_count_ext > w_keff) && (i_accuracy_key >= r_thr);
    assign w_new       = {i_case_tag, i_reason_code, i_accuracy_key};

    // key of the last kept cell after a cut
    always_comb begin
        w_cut_key = '0;
        for (int i = 0; i < NCELL; i++) begin
            if (LW'(i) == (w_keff - LW'(1))) begin
                w_cut_key = w_cut_key | w_data[i][KEY_WIDTH-1:0];
            end
        end
    end

    // next-state and cell operation
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pass       = r_pass;
        n_thr        = r_thr;
        n_from_drain = r_from_drain;
        n_keep       = r_keep;
        n_limit      = r_limit;
        w_ctl.op     = CELL_HOLD;

        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KEEP_COUNT:   n_keep  = i_cfg_data[KEEP_REG_W-1:0];
                REG_BUFFER_LIMIT: n_limit = i_cfg_data[LIMIT_REG_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_req_type == REQ_RECORD) begin
                        if (!w_drop) begin
                            w_ctl.op = CELL_LOAD;
                            n_count  = r_count + CNT_W'(1);
                            // appended count beyond the limit starts compaction
                            if ((w_count_ext + LW'(1)) > w_lim) begin
                                n_state      = ST_SORT;
                                n_pass       = '0;
                                n_from_drain = 1'b0;
                            end
                        end
                    end else begin
                        if (w_count_ext > w_keff) begin
                            n_state      = ST_SORT;
                            n_pass       = '0;
                            n_from_drain = 1'b1;
                        end else if (r_count == '0) begin
                            n_state = ST_EMPTY;
                        end else begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_SORT: begin
                w_ctl.op = r_pass[0] ? CELL_SORT_ODD : CELL_SORT_EVN;
                n_pass   = r_pass + CNT_W'(1);
                if (r_pass == CNT_W'(NCELL - 1)) begin
                    n_state = ST_CUT;
                end
            end
            ST_CUT: begin
                w_ctl.op = CELL_CUT;
                n_count  = CNT_W'(w_keff);
                if (r_from_drain) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_thr   = w_cut_key;
                    n_state = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (w_out_acc) begin
                    w_ctl.op = CELL_SHIFT;
                    n_count  = r_count - CNT_W'(1);
                    if (o_out_last) begin
                        n_state = ST_IDLE;
                        n_thr   = '1;
                    end
                end
            end
            ST_EMPTY: begin
                if (w_out_acc) begin
                    n_state = ST_IDLE;
                    n_thr   = '1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_pass       <= '0;
            r_thr        <= '1;
            r_from_drain <= 1'b0;
            r_keep       <= KEEP_RST;
            r_limit      <= LIMIT_RST;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pass       <= n_pass;
            r_thr        <= n_thr;
            r_from_drain <= n_from_drain;
            r_keep       <= n_keep;
            r_limit      <= n_limit;
        end
    end

    // row of entry cells, cell 0 holds the oldest or smallest entry
    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            logic [ENT_W-1:0] w_ld, w_rd;
            logic             w_lv, w_rv;
            if (g == 0) begin : g_first
                assign w_ld = '0;
                assign w_lv = 1'b0;
            end else begin : g_mid_l
                assign w_ld = w_data[g-1];
                assign w_lv = w_valid[g-1];
            end
            if (g == NCELL - 1) begin : g_last
                assign w_rd = '0;
                assign w_rv = 1'b0;
            end else begin : g_mid_r
                assign w_rd = w_data[g+1];
                assign w_rv = w_valid[g+1];
            end
            tkr_cell #(
                .ENT_W     (ENT_W),
                .KEY_WIDTH (KEY_WIDTH),
                .CW        (LW),
                .INDEX     (g)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_keep        (w_keff),
                .i_new         (w_new),
                .i_left_data   (w_ld),
                .i_left_valid  (w_lv),
                .i_right_data  (w_rd),
                .i_right_valid (w_rv),
                .o_data        (w_data[g]),
                .o_valid       (w_valid[g])
            );
        end
    endgenerate

    // drain payload comes straight from cell 0, last from the valid bit of cell 1
    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = (r_state == ST_DRAIN) || (r_state == ST_EMPTY);
    assign o_out_empty  = (r_state == ST_EMPTY);
    assign o_out_last   = (r_state == ST_EMPTY) || !w_valid[1];
    assign o_out_tag    = o_out_empty ? '0 : w_data[0][ENT_W-1 -: TAG_WIDTH];
    assign o_out_reason = o_out_empty ? '0 : w_data[0][KEY_WIDTH +: REASON_W];
    assign o_out_key    = o_out_empty ? '0 : w_data[0][KEY_WIDTH-1:0];

    // no new request while results are pending
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input not stalled while output pending");

    // a drain beat always comes from a filled cell
    a_drain_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> w_valid[0])
        else $error("drain from empty cell");

    // after a cut the count equals the effective keep count
    a_cut_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CUT) |=> (LW'(r_count) == $past(w_keff)))
        else $error("count wrong after cut");

endmodule

// ===== bench/tb_top_k_min_key_recorder.sv =====
module tb_top_k_min_key_recorder;
    import tkr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BUF   = DEF_MAX_BUFFER;
    localparam int MAX_KP    = DEF_MAX_KEEP;
    localparam int KEY_W     = DEF_KEY_WIDTH;
    localparam int TAG_W     = DEF_TAG_WIDTH;
    // covers the sort passes and cut of a compaction, with slack for the drain start
    localparam int SETTLE    = MAX_BUF + 12;
    localparam int HOLD_LEN  = 300;
    localparam int WDOG_MAX  = 4000;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [REASON_W-1:0] reason;
        logic [KEY_W-1:0]    key;
        logic                empty;
        logic                last;
    } t_drain_beat;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_req_type;
    logic [TAG_W-1:0]       i_case_tag;
    logic [REASON_W-1:0]    i_reason_code;
    logic [KEY_W-1:0]       i_accuracy_key;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [TAG_W-1:0]       o_out_tag;
    logic [REASON_W-1:0]    o_out_reason;
    logic [KEY_W-1:0]       o_out_key;
    logic                   o_out_empty;
    logic                   o_out_last;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    top_k_min_key_recorder u_top (.*);

    // mirror of the kept-entry store
    logic [TAG_W-1:0]       kept_tag [MAX_BUF+1];
    logic [REASON_W-1:0]    kept_reason [MAX_BUF+1];
    logic [KEY_W-1:0]       kept_key [MAX_BUF+1];
    int                     kept_cnt;
    logic [KEY_W-1:0]       drop_thr;
    logic [KEEP_REG_W-1:0]  keep_reg;
    logic [LIMIT_REG_W-1:0] limit_reg;

    t_drain_beat            drain_q[$];
    int                     err_cnt;
    bit                     idle_on;
    bit                     hold_go;
    int                     quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int keep_eff();
        int k;
        k = keep_reg;
        if (k < 1) k = 1;
        if (k > MAX_KP) k = MAX_KP;
        return k;
    endfunction

    function automatic int limit_eff(int k);
        int b;
        b = limit_reg;
        if (b < k) b = k;
        if (b > MAX_BUF) b = MAX_BUF;
        return b;
    endfunction

    // stable ascending sort, then keep the k best
    function automatic void sort_keep_best(int k);
        logic [TAG_W-1:0]    t;
        logic [REASON_W-1:0] r;
        logic [KEY_W-1:0]    kv;
        int j;
        for (int i = 1; i < kept_cnt; i++) begin
            t  = kept_tag[i];
            r  = kept_reason[i];
            kv = kept_key[i];
            j  = i;
            while (j > 0 && kept_key[j-1] > kv) begin
                kept_tag[j]    = kept_tag[j-1];
                kept_reason[j] = kept_reason[j-1];
                kept_key[j]    = kept_key[j-1];
                j--;
            end
            kept_tag[j]    = t;
            kept_reason[j] = r;
            kept_key[j]    = kv;
        end
        if (kept_cnt > k) kept_cnt = k;
    endfunction

    function automatic void predict_beat(t_req req, logic [TAG_W-1:0] tag,
                                         logic [REASON_W-1:0] reason, logic [KEY_W-1:0] key);
        int k;
        int lim;
        t_drain_beat b;
        k   = keep_eff();
        lim = limit_eff(k);
        if (req == REQ_RECORD) begin
            // rejected once the store is past keep and the key is no better
            if (kept_cnt > k && key >= drop_thr) return;
            if (kept_cnt <= MAX_BUF) begin
                kept_tag[kept_cnt]    = tag;
                kept_reason[kept_cnt] = reason;
                kept_key[kept_cnt]    = key;
                kept_cnt++;
            end
            if (kept_cnt > lim) begin
                sort_keep_best(k);
                drop_thr = kept_key[kept_cnt-1];
            end
        end else begin
            if (kept_cnt > k) sort_keep_best(k);
            if (kept_cnt == 0) begin
                b = '0;
                b.empty = 1'b1;
                b.last  = 1'b1;
                drain_q.push_back(b);
            end else begin
                for (int i = 0; i < kept_cnt; i++) begin
                    b.tag    = kept_tag[i];
                    b.reason = kept_reason[i];
                    b.key    = kept_key[i];
                    b.empty  = 1'b0;
                    b.last   = (i == kept_cnt - 1);
                    drain_q.push_back(b);
                end
            end
            kept_cnt = 0;
            drop_thr = '1;
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_beat(t_req req, logic [TAG_W-1:0] tag,
                             logic [REASON_W-1:0] reason, logic [KEY_W-1:0] key);
        // random gap before the beat, in bursts
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_case_tag     <= tag;
        i_reason_code  <= reason;
        i_accuracy_key <= key;
        do @(posedge i_clk); while (o_in_stall);
        predict_beat(req, tag, reason, key);
    endtask

    // drop valid, wait for every drain beat, then let a compaction finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (drain_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_KEEP_COUNT) keep_reg = val[KEEP_REG_W-1:0];
        else limit_reg = val;
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] keep, logic [CFG_DATA_W-1:0] lim);
        wait_idle();
        write_reg(REG_KEEP_COUNT, keep);
        write_reg(REG_BUFFER_LIMIT, lim);
    endtask

    // keys mostly from a narrow range so ties and threshold hits are common
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            2, 3, 4: return KEY_W'($urandom);
            default: return KEY_W'($urandom_range(0, 40));
        endcase
    endfunction

    task automatic send_record();
        send_beat(REQ_RECORD, TAG_W'($urandom), REASON_W'($urandom_range(0, 3)), pick_key());
    endtask

    // drain beats carry random junk in the ignored fields
    task automatic send_drain();
        send_beat(REQ_DRAIN, TAG_W'($urandom), REASON_W'($urandom_range(0, 3)),
                  KEY_W'($urandom));
    endtask

    task automatic run_mix(int n, int drain_odds);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1, drain_odds) == 1) send_drain();
            else send_record();
        end
        send_drain();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_extremes();
        send_drain();                                   // empty store
        set_config(4, 6);
        send_beat(REQ_RECORD, '0, 2'd0, '1);
        send_beat(REQ_RECORD, '1, 2'd3, '0);
        send_beat(REQ_RECORD, 16'h5a5a, 2'd1, 32'd7);
        send_beat(REQ_RECORD, 16'ha5a5, 2'd2, 32'd7);   // tie with the one before
        send_beat(REQ_RECORD, 16'h0001, 2'd1, 32'd3);
        send_beat(REQ_RECORD, 16'h0002, 2'd2, 32'd9);
        send_beat(REQ_RECORD, 16'h0003, 2'd3, 32'd7);   // past limit, compaction
        send_beat(REQ_RECORD, 16'h0004, 2'd0, 32'd7);   // at threshold
        send_beat(REQ_RECORD, 16'h0005, 2'd1, 32'd8);   // above threshold
        send_beat(REQ_RECORD, 16'h0006, 2'd2, 32'd1);
        send_beat(REQ_DRAIN, '1, 2'd3, '1);
        send_drain();                                   // empty right after a drain
        send_beat(REQ_RECORD, 16'h0007, 2'd0, 32'd5);
        send_beat(REQ_RECORD, 16'h0008, 2'd0, 32'd2);
        send_drain();                                   // under keep, arrival order
    endtask

    task automatic test_config_sweep();
        // defaults, clamps at both ends, keep above limit, small and mid settings
        set_config(8, 32);  run_mix(70, 10);
        set_config(1, 1);   run_mix(60, 6);
        set_config(0, 0);   run_mix(50, 6);
        set_config(31, 63); run_mix(70, 12);
        set_config(16, 2);  run_mix(60, 10);
        set_config(5, 12);  run_mix(60, 8);
        set_config(CFG_DATA_W'($urandom_range(0, 31)), CFG_DATA_W'($urandom_range(0, 63)));
        run_mix(50, 8);
    endtask

    task automatic test_output_hold();
        set_config(16, 20);
        hold_go = 1'b1;                                 // receiver stops for a long stretch
        for (int i = 0; i < 20; i++) send_record();
        send_drain();
        for (int i = 0; i < 10; i++) send_record();     // stalled behind the drain
        send_drain();
    endtask

    task automatic test_sender_pause();
        set_config(3, 8);
        for (int i = 0; i < 12; i++) send_record();
        send_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (drain_q.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 12; i++) send_record();
        send_drain();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        set_config(6, 16);
        run_mix(50, 9);
    endtask

    // ---------------------------------------------------------------- checking

    always @(posedge i_clk) begin
        t_drain_beat exp_b;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drain_q.size() == 0) begin
                $error("drain beat with nothing expected");
                err_cnt++;
            end else begin
                exp_b = drain_q.pop_front();
                if (o_out_tag !== exp_b.tag) begin
                    $error("out_tag exp %h got %h", exp_b.tag, o_out_tag);
                    err_cnt++;
                end
                if (o_out_reason !== exp_b.reason) begin
                    $error("out_reason exp %h got %h", exp_b.reason, o_out_reason);
                    err_cnt++;
                end
                if (o_out_key !== exp_b.key) begin
                    $error("out_key exp %h got %h", exp_b.key, o_out_key);
                    err_cnt++;
                end
                if (o_out_empty !== exp_b.empty) begin
                    $error("out_empty exp %b got %b", exp_b.empty, o_out_empty);
                    err_cnt++;
                end
                if (o_out_last !== exp_b.last) begin
                    $error("out_last exp %b got %b", exp_b.last, o_out_last);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stall: random bursts, or one long hold on request
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static int burst_left = 0;
        static bit hold_seen = 1'b0;
        if (hold_go && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("top_k_min_key_recorder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_req_type     <= REQ_RECORD;
        i_case_tag     <= '0;
        i_reason_code  <= '0;
        i_accuracy_key <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_KEEP_COUNT;
        i_cfg_data     <= '0;
        idle_on   = 1'b1;
        hold_go   = 1'b0;
        kept_cnt  = 0;
        drop_thr  = '1;
        keep_reg  = KEEP_RST;
        limit_reg = LIMIT_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_config_sweep();
        test_output_hold();
        test_sender_pause();
        test_full_rate();

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (drain_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("top_k_min_key_recorder verification clean");
        end else begin
            $display("top_k_min_key_recorder verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tkr_pkg.sv
rtl/tkr_cell.sv
rtl/top_k_min_key_recorder.sv
bench/tb_top_k_min_key_recorder.sv
